// ===== sv/dtw_pkg.sv =====
// Package for the DTW cost and warp path block.
// Holds shared widths, action codes and the cell-to-cell struct; no dependencies.
`timescale 1ns / 1ps
package dtw_pkg;
	localparam int MAX_LEN    = 32;
	localparam int SAMPLE_W   = 16;
	localparam int COST_W     = 48;
	localparam int CFG_W      = 6;
	localparam int ACT_W      = 2;
	localparam logic [ACT_W-1:0] ACT_LOAD_K = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOAD_S = 2'd1;
	localparam logic [ACT_W-1:0] ACT_RUN    = 2'd2;
	localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;
	localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};

	typedef struct packed {
		logic              vld;
		logic              first;
		logic [COST_W-1:0] left;
		logic [COST_W-1:0] diag;
	} wave_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
		input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction
endpackage

// ===== sv/dtw_ram.sv =====
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dtw_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== sv/dtw_cell.sv =====
// One column cell of the DTW chain: holds one kernel sample and the cost
// of its column in the previous row. Uses dtw_pkg.
`timescale 1ns / 1ps
module dtw_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                kwe,
	input  logic signed [dtw_pkg::SAMPLE_W-1:0] kdata,
	input  logic signed [dtw_pkg::SAMPLE_W-1:0] sdata,
	input  logic                                row0,
	input  dtw_pkg::wave_t                      win,
	output dtw_pkg::wave_t                      wout,
	output logic [dtw_pkg::COST_W-1:0]          cost
);
	import dtw_pkg::*;
	logic signed [SAMPLE_W-1:0] k_q;
	logic [COST_W-1:0] up_q, left_q, diag_q;
	logic vld_q;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0] mag;
	logic [2*SAMPLE_W+1:0] sq;
	logic [COST_W-1:0] best, c;

	always_comb begin
		diff = {k_q[SAMPLE_W-1], k_q} - {sdata[SAMPLE_W-1], sdata};
		mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
		sq   = mag * mag;
		if (row0 && win.first) best = '0;
		else if (row0) best = win.left;
		else if (win.first) best = up_q;
		else begin
			best = win.diag;
			if (up_q < best) best = up_q;
			if (win.left < best) best = win.left;
		end
		c = sat_add(best, COST_W'(sq));
	end

	always_ff @(posedge clk) if (kwe) k_q <= kdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= win.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (win.vld) begin
			left_q <= c;
			diag_q <= up_q;
			up_q   <= c;
		end
	end

	assign wout = {vld_q, 1'b0, left_q, diag_q};
	assign cost = c;
endmodule

// ===== sv/dtw_cost_and_warp_path.sv =====
// Top level of the DTW cost and warp path block: chain of column cells,
// cost RAM and backtrack sequencer. Uses dtw_pkg, dtw_cell, dtw_ram.
//
// Usage: s_tdata carries {sample, index, action}. Action 0/1 loads a kernel
// or sequence sample (no result). Action 2 runs: the chain of
// cells computes one matrix row per step, sequence_length rows of
// kernel_length cells, each cell row stored in the cost RAM. The row is
// evaluated by walking a wavefront across the cells, one cell per cycle.
// The backtrack then reads the up, left and diagonal neighbors from the
// RAM for each path point off row 0 and column 0, and emits one word per
// point, last cell first, with tlast set on the final point (0,0).
// The block takes no new word while a run is in progress. A stalled
// receiver holds the output register and the backtrack waits. Reset clears
// control state and sets both lengths to 32; the sample and cost stores
// are undefined until written. Configuration writes take effect at once.
`timescale 1ns / 1ps
module dtw_cost_and_warp_path #(
	parameter int MAX_LENGTH = dtw_pkg::MAX_LEN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [dtw_pkg::CFG_W-1:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action[1:0], index[6:2], sample[22:7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // kernel_index[4:0], sequence_index[9:5], total_cost[57:10]
	output logic        m_tlast   // last_point
);
	import dtw_pkg::*;
	localparam int LW = $clog2(MAX_LENGTH);
	localparam int AW = 2 * LW;
	localparam logic [2:0] ST_IDLE = 3'd0, ST_ROW = 3'd1, ST_DRAIN = 3'd2,
		ST_RD = 3'd3, ST_WT = 3'd4, ST_DEC = 3'd5, ST_OUT = 3'd6;

	logic [CFG_W-1:0] klen_q, slen_q;
	logic [2:0] st_q;
	logic [LW-1:0] kl, sl, i_q, j_q, col_q;
	logic [1:0] rd_q;
	logic [COST_W-1:0] up_q, lf_q, total_q;
	logic signed [SAMPLE_W-1:0] s_mem_q [MAX_LENGTH];
	logic signed [SAMPLE_W-1:0] srow_q;
	wave_t wv [MAX_LENGTH+1];
	logic [COST_W-1:0] cc [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] kwe;
	logic [ACT_W-1:0] act;
	logic [LW-1:0] lidx;
	logic idx_ok;
	logic ram_we;
	logic [AW-1:0] waddr, raddr;
	logic [COST_W-1:0] wdata, rdata;
	logic [LW-1:0] ri, rj;

	function automatic logic [LW-1:0] eff(input logic [CFG_W-1:0] v);
		if (v == '0) return '0;
		if (v > CFG_W'(MAX_LENGTH)) return LW'(MAX_LENGTH - 1);
		return LW'(v - 1'b1);
	endfunction

	assign kl = eff(klen_q);
	assign sl = eff(slen_q);
	assign act = s_tdata[1:0];
	assign idx_ok = ({1'b0, s_tdata[6:2]} < 6'(MAX_LENGTH));
	assign lidx = s_tdata[2 +: LW];
	assign s_tready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= CFG_W'(32);
			slen_q <= CFG_W'(32);
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) klen_q <= cfg_data;
			else slen_q <= cfg_data;
		end
	end

	always_comb
		for (int k = 0; k < MAX_LENGTH; k++)
			kwe[k] = s_tvalid && s_tready && act == ACT_LOAD_K && idx_ok && lidx == LW'(k);

	always_ff @(posedge clk)
		if (s_tvalid && s_tready && act == ACT_LOAD_S && idx_ok) s_mem_q[lidx] <= s_tdata[22:7];

	// wavefront injection at column 0
	always_comb begin
		wv[0].vld   = (st_q == ST_ROW) && col_q == '0;
		wv[0].first = 1'b1;
		wv[0].left  = '0;
		wv[0].diag  = '0;
	end

	genvar g;
	generate
		for (g = 0; g < MAX_LENGTH; g++) begin : g_cell
			dtw_cell u_cell (
				.clk(clk), .arst_n(arst_n), .kwe(kwe[g]), .kdata(s_tdata[22:7]),
				.sdata(srow_q), .row0(i_q == '0), .win(wv[g]), .wout(wv[g+1]),
				.cost(cc[g])
			);
		end
	endgenerate

	assign ram_we = (st_q == ST_ROW) && wv[col_q].vld;
	assign waddr  = {i_q, col_q};
	assign wdata  = cc[col_q];

	always_comb begin
		ri = i_q; rj = j_q;
		unique case (rd_q)
			2'd0: ri = i_q - 1'b1;
			2'd1: rj = j_q - 1'b1;
			default: begin ri = i_q - 1'b1; rj = j_q - 1'b1; end
		endcase
	end
	assign raddr = {ri, rj};

	dtw_ram #(.WIDTH(COST_W), .DEPTH(1 << AW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			m_tvalid <= 1'b0;
			i_q <= '0; j_q <= '0; col_q <= '0; rd_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (s_tvalid && act == ACT_RUN) begin
					i_q <= '0; col_q <= '0;
					srow_q <= s_mem_q[0];
					st_q <= ST_ROW;
				end
				ST_ROW: begin
					if (col_q == kl) begin
						col_q <= '0;
						if (i_q == sl) begin
							st_q <= ST_DRAIN;
							total_q <= cc[col_q];
							j_q <= kl;
						end else begin
							i_q <= i_q + 1'b1;
							srow_q <= s_mem_q[i_q + 1'b1];
						end
					end else col_q <= col_q + 1'b1;
				end
				ST_DRAIN: st_q <= ST_OUT;
				ST_OUT: if (!m_tvalid || m_tready) begin
					m_tvalid <= 1'b1;
					m_tdata <= {6'd0, total_q, 5'(i_q), 5'(j_q)};
					m_tlast <= (i_q == '0) && (j_q == '0);
					if (i_q == '0 && j_q == '0) st_q <= ST_IDLE;
					else if (i_q == '0) j_q <= j_q - 1'b1;
					else if (j_q == '0) i_q <= i_q - 1'b1;
					else begin rd_q <= 2'd0; st_q <= ST_RD; end
				end else if (m_tready) m_tvalid <= 1'b0;
				ST_RD: st_q <= ST_WT;
				ST_WT: begin
					if (rd_q == 2'd0) begin up_q <= rdata; rd_q <= 2'd1; st_q <= ST_RD; end
					else if (rd_q == 2'd1) begin lf_q <= rdata; rd_q <= 2'd2; st_q <= ST_RD; end
					else st_q <= ST_DEC;
				end
				ST_DEC: begin
					if (up_q <= lf_q && up_q <= rdata) i_q <= i_q - 1'b1;
					else if (lf_q <= rdata) j_q <= j_q - 1'b1;
					else begin i_q <= i_q - 1'b1; j_q <= j_q - 1'b1; end
					st_q <= ST_OUT;
				end
				default: st_q <= ST_IDLE;
			endcase
			if (st_q != ST_OUT && m_tvalid && m_tready) m_tvalid <= 1'b0;
		end
	end
endmodule
